>>> hdl/assert_macros.svh
// assertion macros used by position_move_controller_top
// no dependencies; the checks drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked on every rising clock edge outside reset
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hdl/pmc_pkg.sv
// types and constants for the position move controller
// no dependencies; used by position_move_controller_top
`timescale 1ns / 1ps

package pmc_pkg;

    // controller phase codes
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_COARSE = 2'd1,
        PH_FINE   = 2'd2,
        PH_FAULT  = 2'd3
    } t_phase;

    // drive limits
    localparam int DRIVE_LIMIT    = 100;
    localparam int FINE_TOLERANCE = 1;
    localparam int DRIVE_W        = 8;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRUISE_SPEED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STALL_WINDOW = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STALL_MIN    = 2'd2;

    // register widths and reset values
    localparam int CRUISE_W = 7;
    localparam int WINDOW_W = 10;
    localparam int MIN_W    = 8;
    localparam logic [CRUISE_W-1:0] CRUISE_RESET = 7'd25;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 10'd500;
    localparam logic [MIN_W-1:0]    MIN_RESET    = 8'd3;

    // result stream width: drive, phase, done, fault, cup lost, padded to bytes
    localparam int OUT_DATA_W = 16;

endpackage

>>> hdl/position_move_controller_top.sv
// position move controller: coarse travel, stall check, fine approach
// depends on pmc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Position move controller. Each request is either a start command (tuser 0),
// which latches target, direction and load presence and answers with cruise
// drive, or a one millisecond sample tick (tuser 1), which advances coarse
// travel, the windowed stall check, fine approach or the load-loss abort and
// answers with one result. Every request gives exactly one result. Requests
// are taken one per clock cycle unless results stall; each result passes
// the input register and the result register around the combinational
// control step. The result register lets a new request in while a finished
// result waits downstream. The user must write configuration through the
// cfg port only while no request is in flight; the block does not check it.
module position_move_controller_top #(
    parameter int POS_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [pmc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [pmc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // target_position, encoder_position, cup_present, zero pad
    input  logic [((2*POS_BITS+8)/8)*8-1:0]  s_axis_tdata,
    // command
    input  logic                             s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // motor_drive, phase, move_done, stall_fault, cup_lost, zero pad
    output logic [pmc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int D = POS_BITS + 1;
    localparam int DW = pmc_pkg::DRIVE_W;
    localparam logic signed [D-1:0] TOL   = D'(pmc_pkg::FINE_TOLERANCE);
    localparam logic signed [D-1:0] LIM_P = D'(pmc_pkg::DRIVE_LIMIT);
    localparam logic signed [D-1:0] LIM_N = -D'(pmc_pkg::DRIVE_LIMIT);

    // configuration registers
    logic [pmc_pkg::CRUISE_W-1:0] r_cruise;
    logic [pmc_pkg::WINDOW_W-1:0] r_window;
    logic [pmc_pkg::MIN_W-1:0]    r_min_travel;

    // input register
    logic                       r_in_valid;
    logic                       r_in_cmd;
    logic signed [POS_BITS-1:0] r_in_target;
    logic signed [POS_BITS-1:0] r_in_enc;
    logic                       r_in_cup;

    // controller state
    pmc_pkg::t_phase            r_phase, n_phase;
    logic                       r_reverse, n_reverse;
    logic signed [POS_BITS-1:0] r_goal, n_goal;
    logic                       r_had_load, n_had_load;
    logic signed [POS_BITS-1:0] r_last_pos, n_last_pos;
    logic [pmc_pkg::WINDOW_W-1:0] r_win_cnt, n_win_cnt;

    // result register
    logic                 r_out_valid;
    logic signed [DW-1:0] r_out_drive, n_drive;
    logic [1:0]           r_out_phase;
    logic                 r_out_done, n_done;
    logic                 r_out_fault;
    logic                 r_out_lost, n_lost;

    // handshake
    logic w_adv, w_fire;
    assign w_adv  = !r_out_valid || m_axis_tready;
    assign w_fire = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    // configuration writes, indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise     <= pmc_pkg::CRUISE_RESET;
            r_window     <= pmc_pkg::WINDOW_RESET;
            r_min_travel <= pmc_pkg::MIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pmc_pkg::CFG_CRUISE_SPEED: r_cruise <= i_cfg_data[pmc_pkg::CRUISE_W-1:0];
                pmc_pkg::CFG_STALL_WINDOW: r_window <= i_cfg_data[pmc_pkg::WINDOW_W-1:0];
                pmc_pkg::CFG_STALL_MIN:    r_min_travel <= i_cfg_data[pmc_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd    <= s_axis_tuser;
            r_in_target <= s_axis_tdata[POS_BITS-1:0];
            r_in_enc    <= s_axis_tdata[2*POS_BITS-1:POS_BITS];
            r_in_cup    <= s_axis_tdata[2*POS_BITS];
        end
    end

    // position arithmetic, one bit wider than the positions
    logic signed [D-1:0] w_enc_x, w_goal_x, w_last_x;
    logic signed [D-1:0] w_rem, w_travel, w_along, w_rem_adj, w_half;
    logic [D-1:0]        w_abs_rem, w_abs_travel;
    assign w_enc_x  = $signed({r_in_enc[POS_BITS-1], r_in_enc});
    assign w_goal_x = $signed({r_goal[POS_BITS-1], r_goal});
    assign w_last_x = $signed({r_last_pos[POS_BITS-1], r_last_pos});
    assign w_rem    = w_goal_x - w_enc_x;
    assign w_travel = w_enc_x - w_last_x;
    assign w_abs_rem    = w_rem[D-1] ? D'(-w_rem) : D'(w_rem);
    assign w_abs_travel = w_travel[D-1] ? D'(-w_travel) : D'(w_travel);
    assign w_along   = r_reverse ? -w_rem : w_rem;
    // halve with truncation toward zero
    assign w_rem_adj = w_rem + $signed({{(D-1){1'b0}}, w_rem[D-1]});
    assign w_half    = w_rem_adj >>> 1;

    // decision signals
    logic w_start, w_active, w_lost_load, w_near, w_check, w_stalled;
    logic w_coarse_run, w_fine_eval, w_arrive, w_start_rev;
    assign w_start      = !r_in_cmd;
    assign w_active     = (r_phase == pmc_pkg::PH_COARSE) || (r_phase == pmc_pkg::PH_FINE);
    assign w_lost_load  = w_active && r_had_load && !r_in_cup;
    assign w_near       = w_abs_rem <= {{(D-pmc_pkg::CRUISE_W-1){1'b0}}, r_cruise, 1'b0};
    assign w_check      = r_win_cnt >= r_window;
    assign w_stalled    = w_abs_travel < {{(D-pmc_pkg::MIN_W){1'b0}}, r_min_travel};
    assign w_coarse_run = !w_start && !w_lost_load && (r_phase == pmc_pkg::PH_COARSE) && !w_near;
    assign w_fine_eval  = !w_start && !w_lost_load &&
                          ((r_phase == pmc_pkg::PH_FINE) ||
                           ((r_phase == pmc_pkg::PH_COARSE) && w_near));
    assign w_arrive     = !(w_along > TOL);
    assign w_start_rev  = r_in_target < r_in_enc;

    // cruise drive magnitude and signed drive
    logic [pmc_pkg::CRUISE_W-1:0] w_cruise_mag;
    logic signed [DW-1:0]         w_cruise_pos;
    logic signed [DW-1:0]         w_fine_drive;
    assign w_cruise_mag = (r_cruise > pmc_pkg::CRUISE_W'(pmc_pkg::DRIVE_LIMIT)) ?
                          pmc_pkg::CRUISE_W'(pmc_pkg::DRIVE_LIMIT) : r_cruise;
    assign w_cruise_pos = $signed({1'b0, w_cruise_mag});
    assign w_fine_drive = (w_half > LIM_P) ? DW'(LIM_P) :
                          (w_half < LIM_N) ? DW'(LIM_N) : w_half[DW-1:0];

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_reverse  = r_reverse;
        n_goal     = r_goal;
        n_had_load = r_had_load;
        n_last_pos = r_last_pos;
        n_win_cnt  = r_win_cnt;
        if (w_start) begin
            n_goal     = r_in_target;
            n_reverse  = w_start_rev;
            n_had_load = r_in_cup;
            n_last_pos = r_in_enc;
            n_win_cnt  = '0;
            n_phase    = pmc_pkg::PH_COARSE;
        end else if (w_lost_load) begin
            n_phase = pmc_pkg::PH_IDLE;
        end else if (w_coarse_run) begin
            if (w_check) begin
                n_win_cnt = '0;
                if (w_stalled) begin
                    n_phase = pmc_pkg::PH_FAULT;
                end else begin
                    n_last_pos = r_in_enc;
                end
            end else begin
                n_win_cnt = r_win_cnt + 1'b1;
            end
        end else if (w_fine_eval) begin
            n_phase = w_arrive ? pmc_pkg::PH_IDLE : pmc_pkg::PH_FINE;
        end
    end

    // result fields
    always_comb begin
        n_drive = '0;
        n_done  = 1'b0;
        n_lost  = 1'b0;
        if (w_start) begin
            n_drive = w_start_rev ? -w_cruise_pos : w_cruise_pos;
        end else if (w_lost_load) begin
            n_lost = 1'b1;
        end else if (w_coarse_run) begin
            if (!(w_check && w_stalled)) begin
                n_drive = r_reverse ? -w_cruise_pos : w_cruise_pos;
            end
        end else if (w_fine_eval) begin
            if (w_arrive) begin
                n_done = 1'b1;
            end else begin
                n_drive = w_fine_drive;
            end
        end
    end

    // controller state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= pmc_pkg::PH_IDLE;
            r_reverse  <= 1'b0;
            r_goal     <= '0;
            r_had_load <= 1'b0;
            r_last_pos <= '0;
            r_win_cnt  <= '0;
        end else if (w_fire) begin
            r_phase    <= n_phase;
            r_reverse  <= n_reverse;
            r_goal     <= n_goal;
            r_had_load <= n_had_load;
            r_last_pos <= n_last_pos;
            r_win_cnt  <= n_win_cnt;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_drive <= n_drive;
            r_out_phase <= n_phase;
            r_out_done  <= n_done;
            r_out_fault <= (n_phase == pmc_pkg::PH_FAULT);
            r_out_lost  <= n_lost;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_lost, r_out_fault, r_out_done, r_out_phase,
                            r_out_drive};

    // checks
    `ASSERT_CHK(a_fault_no_drive, i_clk, i_rst_n,
        (r_out_valid && r_out_fault) |-> (r_out_drive == '0), "drive while stall fault")
    `ASSERT_CHK(a_done_is_idle, i_clk, i_rst_n,
        (r_out_valid && r_out_done) |-> (r_out_phase == pmc_pkg::PH_IDLE && !r_out_lost),
        "move done outside idle")
    `ASSERT_NEVER(a_drive_range, i_clk, i_rst_n,
        r_out_valid && (r_out_drive > DW'(pmc_pkg::DRIVE_LIMIT) ||
        r_out_drive < -DW'(pmc_pkg::DRIVE_LIMIT)), "drive beyond limit")
    `ASSERT_CHK(a_fault_sticky, i_clk, i_rst_n,
        (w_fire && r_phase == pmc_pkg::PH_FAULT && r_in_cmd) |=>
        (r_phase == pmc_pkg::PH_FAULT), "stall fault left without start")

endmodule
